[hw/rtl/crcbsc_pkg.sv]
// Shared types and constants for the bit-serial CRC codec.
`timescale 1ns / 1ps
`default_nettype none

package crcbsc_pkg;

    // Field and bus widths
    localparam int DEG_W = 6;
    localparam int TAPS_W = 32;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd16;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 32'h0000_1021;

    // Register index, taken from paddr[2]
    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_TAPS = 1'b1;

    // Item kind
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // Control broadcast to every cell of the remainder chain
    typedef struct packed {
        logic en;     // update the cells this cycle
        logic clear;  // load zero instead of the computed value
        logic fb;     // feedback, xored into tapped cells
    } t_cell_ctrl;

endpackage

`default_nettype wire

[hw/rtl/crcbsc_cell.sv]
// One remainder bit of the CRC chain: shift from neighbor, xor tap on feedback.
`timescale 1ns / 1ps
`default_nettype none

module crcbsc_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  crcbsc_pkg::t_cell_ctrl  i_ctrl,
    input  wire                     i_prev,
    input  wire                     i_tap,
    input  wire                     i_active,
    output logic                    o_bit,
    output logic                    o_next
);

    logic r_bit;

    // Cells at or above the degree always load zero
    assign o_next = i_active & (i_prev ^ (i_ctrl.fb & i_tap));
    assign o_bit = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.en) begin
            r_bit <= i_ctrl.clear ? 1'b0 : o_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/crcbsc_chain.sv]
// Row of remainder cells with the top-bit select and next-remainder zero test.
`timescale 1ns / 1ps
`default_nettype none

module crcbsc_chain #(
    parameter int MAX_DEGREE = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  crcbsc_pkg::t_cell_ctrl               i_ctrl,
    input  wire                                  i_din,
    input  wire [crcbsc_pkg::DEG_W-1:0]          i_degree,
    input  wire [crcbsc_pkg::TAPS_W-1:0]         i_taps,
    output logic                                 o_top,
    output logic                                 o_next_zero
);

    localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [MAX_DEGREE-1:0] w_bits;
    logic [MAX_DEGREE-1:0] w_next;
    logic [IDX_W-1:0]      w_top_idx;

    genvar k;
    generate
        for (k = 0; k < MAX_DEGREE; k++) begin : g_cell
            logic w_prev;
            logic w_tap;

            if (k == 0) begin : g_first
                assign w_prev = i_din;
            end else begin : g_rest
                assign w_prev = w_bits[k-1];
            end

            if (k < crcbsc_pkg::TAPS_W) begin : g_tap
                assign w_tap = i_taps[k];
            end else begin : g_notap
                assign w_tap = 1'b0;
            end

            crcbsc_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (i_ctrl),
                .i_prev   (w_prev),
                .i_tap    (w_tap),
                .i_active (i_degree > crcbsc_pkg::DEG_W'(k)),
                .o_bit    (w_bits[k]),
                .o_next   (w_next[k])
            );
        end
    endgenerate

    // i_degree is already clamped to 1..MAX_DEGREE
    assign w_top_idx = IDX_W'(i_degree - 6'd1);
    assign o_top = w_bits[w_top_idx];
    assign o_next_zero = ~|w_next;

endmodule

`default_nettype wire

[hw/rtl/crc_bit_serial_codec_top.sv]
// Top level of the bit-serial CRC codec: config port, chain control, output register.
// A result is held in the output register from the cycle after its input transfer.
// Throughput: one input bit per cycle, if the output is free and no drain runs; the
// chain does one shift-and-xor per bit. An encode frame's last bit then shifts the
// remainder out, one CRC bit per cycle while the output is free, degree bits in all.
// Reset (synchronous, active low): degree 16, taps 0x1021, remainder zero, no result held.
`timescale 1ns / 1ps
`default_nettype none

module crc_bit_serial_codec_top #(
    parameter int MAX_DEGREE = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // APB-style configuration port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [crcbsc_pkg::APB_AW-1:0]         paddr,
    input  wire [crcbsc_pkg::APB_DW-1:0]         pwdata,
    output logic [crcbsc_pkg::APB_DW-1:0]        prdata,
    output logic                                 pready,
    // input bit channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire                                  i_kind,
    input  wire                                  i_data_bit,
    input  wire                                  i_last,
    // result channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_code_bit,
    output logic                                 o_is_check_result,
    output logic                                 o_crc_ok,
    output logic                                 o_last_out
);

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);

    // configuration
    logic [crcbsc_pkg::DEG_W-1:0]  r_degree;
    logic [crcbsc_pkg::TAPS_W-1:0] r_taps;
    logic [crcbsc_pkg::DEG_W-1:0]  w_deg_eff;
    logic                          w_reg_idx;
    logic                          w_cfg_wr;

    // control and output register
    crcbsc_pkg::t_cell_ctrl w_ctrl;
    logic                   w_din;
    logic                   w_top;
    logic                   w_next_zero;
    logic                   w_out_free;
    logic                   w_draining;
    logic                   w_acc;
    logic                   w_drain_step;

    logic [CNT_W-1:0] r_drain_cnt, n_drain_cnt;
    logic             r_out_valid, n_out_valid;
    logic             r_code_bit, n_code_bit;
    logic             r_is_chk, n_is_chk;
    logic             r_crc_ok, n_crc_ok;
    logic             r_last_out, n_last_out;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_reg_idx = paddr[2];
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= crcbsc_pkg::DEGREE_RESET;
            r_taps <= crcbsc_pkg::TAPS_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                crcbsc_pkg::REG_DEGREE: r_degree <= pwdata[crcbsc_pkg::DEG_W-1:0];
                crcbsc_pkg::REG_TAPS:   r_taps <= pwdata[crcbsc_pkg::TAPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            crcbsc_pkg::REG_DEGREE:
                prdata = {{(crcbsc_pkg::APB_DW - crcbsc_pkg::DEG_W){1'b0}}, r_degree};
            crcbsc_pkg::REG_TAPS:
                prdata = r_taps;
            default:
                prdata = '0;
        endcase
    end

    // degree 0 acts as 1, above the chain length acts as the chain length
    always_comb begin
        if (r_degree == '0) begin
            w_deg_eff = 6'd1;
        end else if (r_degree > crcbsc_pkg::DEG_W'(MAX_DEGREE)) begin
            w_deg_eff = crcbsc_pkg::DEG_W'(MAX_DEGREE);
        end else begin
            w_deg_eff = r_degree;
        end
    end

    // ---------------- handshake ----------------
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_draining = (r_drain_cnt != '0);
    assign o_in_ready = !w_draining && w_out_free;
    assign w_acc = i_in_valid && o_in_ready;
    assign w_drain_step = w_draining && w_out_free;

    // ---------------- chain control ----------------
    always_comb begin
        w_ctrl = '0;
        w_din = 1'b0;
        if (w_acc) begin
            w_ctrl.en = 1'b1;
            if (i_kind == crcbsc_pkg::KIND_ENCODE) begin
                // dividing message * x^degree: input joins the feedback
                w_ctrl.fb = w_top ^ i_data_bit;
            end else begin
                w_ctrl.fb = w_top;
                w_din = i_data_bit;
                w_ctrl.clear = i_last;
            end
        end else if (w_drain_step) begin
            // plain shift toward the top, zero fills from below
            w_ctrl.en = 1'b1;
        end
    end

    crcbsc_chain #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_din       (w_din),
        .i_degree    (w_deg_eff),
        .i_taps      (r_taps),
        .o_top       (w_top),
        .o_next_zero (w_next_zero)
    );

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_code_bit = r_code_bit;
        n_is_chk = r_is_chk;
        n_crc_ok = r_crc_ok;
        n_last_out = r_last_out;
        n_drain_cnt = r_drain_cnt;
        if (w_acc) begin
            if (i_kind == crcbsc_pkg::KIND_ENCODE) begin
                n_out_valid = 1'b1;
                n_code_bit = i_data_bit;
                n_is_chk = 1'b0;
                n_crc_ok = 1'b0;
                n_last_out = 1'b0;
                if (i_last) begin
                    n_drain_cnt = CNT_W'(w_deg_eff);
                end
            end else if (i_last) begin
                n_out_valid = 1'b1;
                n_code_bit = 1'b0;
                n_is_chk = 1'b1;
                n_crc_ok = w_next_zero;
                n_last_out = 1'b1;
            end
        end else if (w_drain_step) begin
            n_out_valid = 1'b1;
            n_code_bit = w_top;
            n_is_chk = 1'b0;
            n_crc_ok = 1'b0;
            n_last_out = (r_drain_cnt == CNT_W'(1));
            n_drain_cnt = r_drain_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_drain_cnt <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_drain_cnt <= n_drain_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code_bit <= n_code_bit;
        r_is_chk <= n_is_chk;
        r_crc_ok <= n_crc_ok;
        r_last_out <= n_last_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_code_bit = r_code_bit;
    assign o_is_check_result = r_is_chk;
    assign o_crc_ok = r_crc_ok;
    assign o_last_out = r_last_out;

    // ---------------- assertions ----------------
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_cnt <= CNT_W'(MAX_DEGREE))
        else $error("drain count above chain length");

    a_drain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_kind == crcbsc_pkg::KIND_ENCODE) && i_last
        |=> (r_drain_cnt == $past(CNT_W'(w_deg_eff))) && r_out_valid)
        else $error("encode frame end did not start the CRC drain");

    a_check_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_kind == crcbsc_pkg::KIND_CHECK) && i_last
        |=> r_out_valid && r_is_chk && r_last_out)
        else $error("check frame end gave no verdict");

    a_encode_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last_out && !r_is_chk |-> !w_draining)
        else $error("final CRC bit shown while drain still running");

endmodule

`default_nettype wire
